[rtl/spms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spms_pkg
// Shared types, field widths and operation / status codes of the shared-pool
// multi-stack core.
// ----------------------------------------------------------------------------
package spms_pkg;

   // field widths
   localparam int OP_W   = 2;
   localparam int SID_W  = 2;
   localparam int DATA_W = 32;
   localparam int ST_W   = 2;

   // number of stack ids the request field can name
   localparam int NUM_IDS = 2 ** SID_W;

   // default sizes
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_NUM_STACKS = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_TOP  = 2'd2;

   // status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic issue;   // request beat taken: decode, memory access, first updates
      logic finish;  // complete the operation and load the response register
   } spms_cmd_type;

endpackage

[rtl/spms_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spms_req_if
// Request channel: valid / ready handshake with operation, stack id and the
// value to push.
// ----------------------------------------------------------------------------
interface spms_req_if;
   import spms_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [SID_W-1:0]         stack_id;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, op, stack_id, push_value, input ready);
   modport sink   (input valid, op, stack_id, push_value, output ready);
endinterface

[rtl/spms_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spms_rsp_if
// Response channel: valid / ready handshake with top value, status and the
// pool / stack flags.
// ----------------------------------------------------------------------------
interface spms_rsp_if;
   import spms_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] top_value;
   logic [ST_W-1:0]          status;
   logic                     pool_full;
   logic                     stack_empty;

   modport source (output valid, top_value, status, pool_full, stack_empty, input ready);
   modport sink   (input valid, top_value, status, pool_full, stack_empty, output ready);
endinterface

[rtl/spms_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spms_ctrl
// Sequencer of the multi-stack core: takes one request beat, waits for the
// memory read, then hands the result to the response register.
// ----------------------------------------------------------------------------
module spms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output spms_pkg::spms_cmd_type cmd
);
   import spms_pkg::*;

   typedef enum logic {
      IDLE,
      FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // response register can take a new beat
   assign out_free = !rsp_valid_ff || rsp_ready;

   // commands to the datapath
   assign cmd.issue  = req_valid && ready_ff;
   assign cmd.finish = (state_ff == FINISH) && out_free;

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (req_valid && ready_ff) begin
                  state_ff <= FINISH;
                  ready_ff <= 1'b0;
               end
            end
            FINISH: begin
               if (out_free) begin
                  state_ff     <= IDLE;
                  ready_ff     <= 1'b1;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/spms_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spms_dp
// Datapath of the multi-stack core: entry value and link memories, stack
// heads, free-list head and the response register.
// ----------------------------------------------------------------------------
module spms_dp #(
   parameter int CAPACITY   = spms_pkg::DEF_CAPACITY,
   parameter int NUM_STACKS = spms_pkg::DEF_NUM_STACKS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spms_pkg::spms_cmd_type          cmd,
   input  logic [spms_pkg::OP_W-1:0]       req_op,
   input  logic [spms_pkg::SID_W-1:0]      req_stack_id,
   input  logic signed [spms_pkg::DATA_W-1:0] req_push_value,
   output logic signed [spms_pkg::DATA_W-1:0] rsp_top_value,
   output logic [spms_pkg::ST_W-1:0]       rsp_status,
   output logic                            rsp_pool_full,
   output logic                            rsp_stack_empty
);
   import spms_pkg::*;

   // index and link widths; the null link is the code CAPACITY
   localparam int IW    = $clog2(CAPACITY);
   localparam int LW    = $clog2(CAPACITY + 1);
   localparam int HEADS = (NUM_STACKS < NUM_IDS) ? NUM_STACKS : NUM_IDS;
   localparam int HW    = (HEADS > 1) ? $clog2(HEADS) : 1;
   localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

   // storage
   logic [DATA_W-1:0] value_mem [CAPACITY];
   logic [LW-1:0]     link_mem  [CAPACITY];
   logic [DATA_W-1:0] value_rd_ff;
   logic [LW-1:0]     link_rd_ff;
   logic [LW-1:0]     head_ff [HEADS];
   logic [LW-1:0]     free_head_ff;
   logic [LW-1:0]     hwm_ff;   // entries at or above this mark were never written

   // operation held between issue and finish
   logic [OP_W-1:0]   op_ff;
   logic              valid_ff;
   logic [HW-1:0]     hidx_ff;
   logic              ok_ff;
   logic [LW-1:0]     e_ff;
   logic              fresh_ff;

   // response register
   logic [DATA_W-1:0] top_ff;
   logic [ST_W-1:0]   status_ff;
   logic              pool_full_ff;
   logic              stack_empty_ff;

   // issue-side decode
   logic              valid_stack;
   logic [HW-1:0]     hidx;
   logic [LW-1:0]     head_sel;
   logic              ok;
   logic [LW-1:0]     addr;
   logic [IW-1:0]     maddr;
   logic              fresh;
   logic              do_push;
   logic              do_pop;
   logic              do_top;

   // finish-side values
   logic [LW-1:0]     link_val;
   logic [LW-1:0]     head_cur;
   logic [LW-1:0]     free_next;
   logic [LW-1:0]     head_next;
   logic [DATA_W-1:0] top_in;
   logic [ST_W-1:0]   status_in;

   // decode of the request beat against the current heads
   always_comb begin
      valid_stack = {{(32 - SID_W){1'b0}}, req_stack_id} < 32'(NUM_STACKS);
      hidx        = HW'(req_stack_id);
      head_sel    = valid_stack ? head_ff[hidx] : NULL_LINK;
      unique case (req_op)
         OP_PUSH: begin
            ok   = valid_stack && (free_head_ff < NULL_LINK);
            addr = free_head_ff;
         end
         OP_POP, OP_TOP: begin
            ok   = valid_stack && (head_sel < NULL_LINK);
            addr = head_sel;
         end
         default: begin
            ok   = 1'b1;
            addr = free_head_ff;
         end
      endcase
      maddr   = addr[IW-1:0];
      fresh   = addr >= hwm_ff;
      do_push = cmd.issue && ok && (req_op == OP_PUSH);
      do_pop  = cmd.issue && ok && (req_op == OP_POP);
      do_top  = cmd.issue && ok && (req_op == OP_TOP);
   end

   // value memory: write on push, registered read on top
   always_ff @(posedge clock) begin
      if (do_push) begin
         value_mem[maddr] <= req_push_value;
      end
      if (do_top) begin
         value_rd_ff <= value_mem[maddr];
      end
   end

   // link memory: read old link and write the new one at the same entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         link_mem[maddr] <= head_sel;
      end else if (do_pop) begin
         link_mem[maddr] <= free_head_ff;
      end
      if (do_push || do_pop) begin
         link_rd_ff <= link_mem[maddr];
      end
   end

   // link of the accessed entry; untouched entries still chain to the next one
   always_comb begin
      link_val  = fresh_ff ? (e_ff + LW'(1)) : link_rd_ff;
      head_cur  = valid_ff ? head_ff[hidx_ff] : NULL_LINK;
      free_next = ((op_ff == OP_PUSH) && ok_ff) ? link_val : free_head_ff;
      head_next = ((op_ff == OP_POP) && ok_ff) ? link_val : head_cur;
      unique case (op_ff)
         OP_PUSH: begin
            top_in    = '0;
            status_in = ok_ff ? ST_OK : ST_OVERFLOW;
         end
         OP_POP: begin
            top_in    = '0;
            status_in = ok_ff ? ST_OK : ST_UNDERFLOW;
         end
         OP_TOP: begin
            top_in    = ok_ff ? value_rd_ff : '1;
            status_in = ok_ff ? ST_OK : ST_UNDERFLOW;
         end
         default: begin
            top_in    = '0;
            status_in = ST_OK;
         end
      endcase
   end

   // list heads and the never-written mark
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HEADS; i++) begin
            head_ff[i] <= NULL_LINK;
         end
         free_head_ff <= '0;
         hwm_ff       <= '0;
      end else begin
         if (do_push) begin
            head_ff[hidx] <= free_head_ff;
            if (fresh) begin
               hwm_ff <= hwm_ff + LW'(1);
            end
         end
         if (do_pop) begin
            free_head_ff <= head_sel;
         end
         if (cmd.finish && ok_ff && (op_ff == OP_PUSH)) begin
            free_head_ff <= link_val;
         end
         if (cmd.finish && ok_ff && (op_ff == OP_POP)) begin
            head_ff[hidx_ff] <= link_val;
         end
      end
   end

   // operation context held to the finish cycle
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         op_ff    <= req_op;
         valid_ff <= valid_stack;
         hidx_ff  <= hidx;
         ok_ff    <= ok;
         e_ff     <= addr;
         fresh_ff <= fresh;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         top_ff         <= top_in;
         status_ff      <= status_in;
         pool_full_ff   <= free_next >= NULL_LINK;
         stack_empty_ff <= head_next >= NULL_LINK;
      end
   end

   assign rsp_top_value   = top_ff;
   assign rsp_status      = status_ff;
   assign rsp_pool_full   = pool_full_ff;
   assign rsp_stack_empty = stack_empty_ff;

endmodule

[rtl/shared_pool_multi_stack_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_core
// Several LIFO stacks sharing one pool of linked entries with a free list.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one operation per beat: op (push, pop, read top),
//   stack_id and push_value. rsp_chan returns exactly one beat per request
//   with top_value, status (ok, overflow, underflow), pool_full and
//   stack_empty, in request order.
//   Each request is accepted in IDLE, where the accept cycle reads the entry
//   link or value from the synchronous pool memory; FINISH then applies the
//   read link to the free-list or stack head and loads the response register.
//   The response is valid the cycle after that; a new request can be taken
//   while the response still waits, but only once the previous request has
//   finished.
//   If the receiver stalls, the finished operation waits until the response
//   register frees up and req_chan.ready stays low meanwhile.
//   Reset (synchronous) empties every stack and chains all entries into the
//   free list at once; no clearing pass is needed, entries never written
//   are tracked by a high-water mark.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack_core #(
   parameter int CAPACITY   = spms_pkg::DEF_CAPACITY,
   parameter int NUM_STACKS = spms_pkg::DEF_NUM_STACKS
) (
   input  logic       clock,
   input  logic       reset,
   spms_req_if.sink   req_chan,
   spms_rsp_if.source rsp_chan
);
   import spms_pkg::*;

   spms_cmd_type cmd;

   // sequencer
   spms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // pool memories, heads and response register
   spms_dp #(
      .CAPACITY   (CAPACITY),
      .NUM_STACKS (NUM_STACKS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_chan.op),
      .req_stack_id    (req_chan.stack_id),
      .req_push_value  (req_chan.push_value),
      .rsp_top_value   (rsp_chan.top_value),
      .rsp_status      (rsp_chan.status),
      .rsp_pool_full   (rsp_chan.pool_full),
      .rsp_stack_empty (rsp_chan.stack_empty)
   );

   // no second request while one is in flight
   a_issue_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> !req_chan.ready)
      else $error("request taken while an operation is in flight");

   // finish always presents a response beat
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_chan.valid)
      else $error("finished operation produced no response beat");

   // issue and finish never overlap
   a_issue_finish: assert property (@(posedge clock) disable iff (reset)
      !(cmd.issue && cmd.finish))
      else $error("issue and finish in the same cycle");

   // a response beat appears only after a finish
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.finish))
      else $error("response beat without a finished operation");

endmodule

[dv/spms_stack_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spms_stack_checker
// Watches the request and response channels of the shared-pool multi-stack
// core, keeps its own linked-pool copy of every stack and the free list,
// works out the response of each accepted request and compares the response
// beats against it in order.
// ----------------------------------------------------------------------------
module spms_stack_checker #(
   parameter int CAPACITY   = spms_pkg::DEF_CAPACITY,
   parameter int NUM_STACKS = spms_pkg::DEF_NUM_STACKS
) (
   input  logic clock,
   input  logic reset,
   spms_req_if  req_mon,
   spms_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   result_count,
   output int   overflow_count,
   output int   underflow_count,
   output int   full_count
);
   import spms_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] top_value;
      logic [ST_W-1:0]   status;
      logic              pool_full;
      logic              stack_empty;
   } stack_rsp_type;

   // null link is the code CAPACITY, anything at or above it reads as null
   localparam int NULL_IDX = CAPACITY;

   // pool state mirrored from the request stream
   logic [DATA_W-1:0] entry_value [CAPACITY];
   int                entry_link  [CAPACITY];
   int                stack_head  [NUM_IDS];
   int                free_head;

   stack_rsp_type owed_rsp_q [$];

   int n_fail      = 0;
   int n_results   = 0;
   int n_overflow  = 0;
   int n_underflow = 0;
   int n_full      = 0;

   // reset image: every entry chained into the free list, all stacks empty
   function automatic void clear_pool();
      for (int i = 0; i < CAPACITY; i++) begin
         entry_value[i] = '0;
         entry_link[i]  = i + 1;
      end
      entry_link[CAPACITY-1] = NULL_IDX;
      for (int s = 0; s < NUM_IDS; s++) stack_head[s] = NULL_IDX;
      free_head = 0;
   endfunction

   // apply one request to the pool and return the response it owes
   function automatic stack_rsp_type run_stack_op(logic [OP_W-1:0] op,
                                                  logic [SID_W-1:0] sid,
                                                  logic [DATA_W-1:0] value);
      stack_rsp_type r;
      int            e;
      bit            known;
      r     = '0;
      known = (int'(sid) < NUM_STACKS);
      case (op)
         OP_PUSH: begin
            if (!known || free_head >= CAPACITY) begin
               r.status = ST_OVERFLOW;
            end else begin
               e               = free_head;
               free_head       = entry_link[e];
               entry_link[e]   = stack_head[sid];
               stack_head[sid] = e;
               entry_value[e]  = value;
            end
         end
         OP_POP: begin
            if (!known || stack_head[sid] >= CAPACITY) begin
               r.status = ST_UNDERFLOW;
            end else begin
               e               = stack_head[sid];
               stack_head[sid] = entry_link[e];
               entry_link[e]   = free_head;
               free_head       = e;
            end
         end
         OP_TOP: begin
            if (!known || stack_head[sid] >= CAPACITY) begin
               r.status    = ST_UNDERFLOW;
               r.top_value = '1;
            end else begin
               r.top_value = entry_value[stack_head[sid]];
            end
         end
         // unused opcode: nothing moves, flags only
         default: ;
      endcase
      r.pool_full   = (free_head >= CAPACITY);
      r.stack_empty = !known || (stack_head[sid] >= CAPACITY);
      return r;
   endfunction

   function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         n_fail++;
      end
   endfunction

   // predict on request beats, compare on response beats
   always @(posedge clock) begin
      stack_rsp_type want;
      if (reset) begin
         clear_pool();
         owed_rsp_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            owed_rsp_q.insert(owed_rsp_q.size(),
                              run_stack_op(req_mon.op, req_mon.stack_id,
                                           req_mon.push_value));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_rsp_q.size() == 0) begin
               $error("response beat with no request outstanding");
               n_fail++;
            end else begin
               want = owed_rsp_q.pop_front();
               check_field("top_value", want.top_value, rsp_mon.top_value);
               check_field("status", DATA_W'(want.status), DATA_W'(rsp_mon.status));
               check_field("pool_full", DATA_W'(want.pool_full),
                           DATA_W'(rsp_mon.pool_full));
               check_field("stack_empty", DATA_W'(want.stack_empty),
                           DATA_W'(rsp_mon.stack_empty));
               n_results++;
               if (want.status == ST_OVERFLOW) n_overflow++;
               if (want.status == ST_UNDERFLOW) n_underflow++;
               if (want.pool_full) n_full++;
            end
         end
      end
      fail_count      <= n_fail;
      pending_count   <= owed_rsp_q.size();
      result_count    <= n_results;
      overflow_count  <= n_overflow;
      underflow_count <= n_underflow;
      full_count      <= n_full;
   end

endmodule

[dv/shared_pool_multi_stack_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_core_test
// Drives push, pop, read-top and unused operations into the core, first a
// directed sweep of empty, full and extreme-value cases, then random bursts
// that fill and drain the shared pool, under three sender / receiver idling
// mixes. A checker beside the core predicts and compares every response.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack_core_test;
   import spms_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int              STALL_LIMIT = 4000;

   logic clock;
   logic reset;

   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int stall_cycles  = 0;

   int fail_count;
   int pending_count;
   int result_count;
   int overflow_count;
   int underflow_count;
   int full_count;

   spms_req_if req_chan ();
   spms_rsp_if rsp_chan ();

   shared_pool_multi_stack_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   spms_stack_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .result_count    (result_count),
      .overflow_count  (overflow_count),
      .underflow_count (underflow_count),
      .full_count      (full_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= rcv_stall_pct);
   end

   // no beat on either channel for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one request beat, with random idle cycles ahead of it
   task automatic send_beat(logic [OP_W-1:0] op, logic [SID_W-1:0] sid,
                            logic [DATA_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.stack_id   <= sid;
      req_chan.push_value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      if ($urandom_range(9) != 0) return $urandom;
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         default: return '0;
      endcase
   endfunction

   // empty stacks, extreme values, filling the pool to overflow
   task automatic directed_sweep();
      send_beat(OP_POP, SID_W'(0), $urandom);
      send_beat(OP_TOP, SID_W'(1), $urandom);
      send_beat(OP_UNUSED, SID_W'(2), $urandom);
      send_beat(OP_PUSH, SID_W'(0), 32'h8000_0000);
      send_beat(OP_PUSH, SID_W'(1), 32'h7fff_ffff);
      send_beat(OP_PUSH, SID_W'(2), 32'hffff_ffff);
      send_beat(OP_PUSH, SID_W'(3), 32'h0000_0000);
      for (int s = 0; s < NUM_IDS; s++) send_beat(OP_TOP, SID_W'(s), '0);
      for (int i = 0; i < DEF_CAPACITY - NUM_IDS; i++) begin
         send_beat(OP_PUSH, SID_W'(i), i[0] ? 32'h5555_5555 : 32'haaaa_aaaa);
      end
      send_beat(OP_PUSH, SID_W'(1), 32'h1234_5678);
      send_beat(OP_UNUSED, SID_W'(0), '0);
   endtask

   // bursts leaning toward push or pop so the pool swings full and empty
   task automatic random_bursts(int count);
      int               left;
      int               burst;
      int               push_pct;
      int               focus;
      int               roll;
      logic [OP_W-1:0]  op;
      logic [SID_W-1:0] sid;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(30, 6);
         case ($urandom_range(2))
            0: push_pct = 70;
            1: push_pct = 25;
            default: push_pct = 45;
         endcase
         focus = $urandom_range(NUM_IDS);
         for (int k = 0; k < burst && left > 0; k++) begin
            roll = $urandom_range(99);
            if (focus < NUM_IDS && $urandom_range(3) != 0) sid = SID_W'(focus);
            else sid = SID_W'($urandom_range(NUM_IDS - 1));
            if (roll < 3) op = OP_UNUSED;
            else if (roll < 3 + push_pct) op = OP_PUSH;
            else if ($urandom_range(2) != 0) op = OP_POP;
            else op = OP_TOP;
            send_beat(op, sid, pick_value());
            left--;
         end
      end
   endtask

   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.op         <= OP_PUSH;
      req_chan.stack_id   <= '0;
      req_chan.push_value <= '0;
      reset               <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // slow receiver
      send_idle_pct = 8;
      rcv_stall_pct = 56;
      directed_sweep();
      random_bursts(175);

      // slow sender
      send_idle_pct = 56;
      rcv_stall_pct = 8;
      random_bursts(175);

      // full rate both ways
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      random_bursts(175);
      req_chan.valid <= 1'b0;

      // drain outstanding responses
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d responses: %0d overflow, %0d underflow, %0d with pool full",
               result_count, overflow_count, underflow_count, full_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
